### rtl/core/dual_sensor_plausibility_display_core_assert.svh
// assertion macros used by the port checker of the plausibility display core
`ifndef DUAL_SENSOR_PLAUSIBILITY_DISPLAY_CORE_ASSERT_SVH
`define DUAL_SENSOR_PLAUSIBILITY_DISPLAY_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define DSPD_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("dspd port check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define DSPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("dspd port check failed");

`endif

### rtl/core/dspd_pkg.sv
// shared constants, types and glyph table of the plausibility display core
`timescale 1ns / 1ps

package dspd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DIGIT_COUNT = 3;
    localparam int PCT_SCALE   = 100;
    localparam int SCALE_BITS  = $clog2(PCT_SCALE);
    localparam int DEC_BASE    = 10;
    localparam int POS_MAX     = 999;

    localparam int QUO_W  = SAMPLE_BITS + SCALE_BITS;
    localparam int MAP_W  = QUO_W + 1;
    localparam int SUM_W  = MAP_W + 1;
    localparam int SPAN_W = SAMPLE_BITS + 1;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int SCAN_W = $clog2(DIGIT_COUNT);

    localparam int CODE_W = 4;
    localparam int SEG_W  = 7;
    localparam int POS_W  = 10;
    localparam int TOL_W  = 8;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = SAMPLE_BITS;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_A_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_A_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_B_LOW  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_B_HIGH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE   = 3'd4;

    localparam logic [SAMPLE_BITS-1:0] RST_SPAN_A_LOW  = 10'd190;
    localparam logic [SAMPLE_BITS-1:0] RST_SPAN_A_HIGH = 10'd833;
    localparam logic [SAMPLE_BITS-1:0] RST_SPAN_B_LOW  = 10'd87;
    localparam logic [SAMPLE_BITS-1:0] RST_SPAN_B_HIGH = 10'd413;
    localparam logic [TOL_W-1:0]       RST_TOLERANCE   = 8'd10;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic CH_A      = 1'b0;
    localparam logic CH_B      = 1'b1;

    localparam logic [CODE_W-1:0] CODE_E = 4'd10;
    localparam logic [CODE_W-1:0] CODE_R = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_CHECK,
        ST_HUND,
        ST_TENS,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic cfg_we;
        logic sample_we;
        logic tick;
        logic div_load;
        logic div_step;
        logic div_store;
        logic div_sel;
        logic check;
        logic hund_step;
        logic tens_step;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic hund_ge;
        logic tens_ge;
        logic out_free;
    } dp_status_t;

    // active-low patterns, codes without a glyph blank the digit
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h18;
            4'd10:   seg = 7'h06;
            4'd11:   seg = 7'h2F;
            default: seg = 7'h7F;
        endcase
        return seg;
    endfunction

endpackage

### rtl/core/dspd_datapath.sv
// registers, shared span divider, plausibility check, digit split and output word
`timescale 1ns / 1ps

module dspd_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dspd_pkg::dp_cmd_t                cmd,
    output dspd_pkg::dp_status_t             status,
    input  logic [dspd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dspd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [dspd_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic [dspd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [dspd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dspd_pkg::*;

    logic [SAMPLE_BITS-1:0] span_a_low_reg, span_a_high_reg;
    logic [SAMPLE_BITS-1:0] span_b_low_reg, span_b_high_reg;
    logic [TOL_W-1:0]       tolerance_reg;
    logic [SAMPLE_BITS-1:0] reading_a_reg, reading_b_reg;
    logic [SCAN_W-1:0]      scan_index_reg, scan_next;
    logic [CODE_W-1:0]      codes_reg [DIGIT_COUNT];

    // divider
    logic [QUO_W-1:0]        dvd_reg;
    logic [SAMPLE_BITS-1:0]  dsr_reg;
    logic [SAMPLE_BITS-1:0]  rem_reg;
    logic                    div_neg_reg;
    logic                    zero_a_reg, zero_b_reg;
    logic signed [MAP_W-1:0] map_a_reg, map_b_reg;

    logic [SAMPLE_BITS-1:0]   ld_x, ld_lo, ld_hi;
    logic signed [SPAN_W-1:0] ld_diff, ld_span;
    logic signed [MAP_W-1:0]  ld_prod;
    logic [QUO_W-1:0]         ld_prod_mag;
    logic [SAMPLE_BITS-1:0]   ld_span_mag;
    logic [SPAN_W-1:0]        rem_shift;
    logic                     rem_ge;
    logic signed [MAP_W-1:0]  quo_s, quo_val;

    // check and digits
    logic signed [SUM_W-1:0] sum, diff, abs_diff, avg;
    logic [SUM_W-1:0]        avg_num;
    logic                    chk_err;
    logic                    err_reg;
    logic [POS_W-1:0]        dig_rem_reg;
    logic [CODE_W-1:0]       hund_reg, tens_reg;

    // output word
    logic                    out_valid_reg;
    logic [SEG_W-1:0]        seg_reg;
    logic [DIGIT_COUNT-1:0]  en_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    fault_reg;
    logic [SCAN_W-1:0]       out_idx;
    logic                    cur_fault;
    logic [POS_W-1:0]        cur_pos;

    assign scan_next = (scan_index_reg == SCAN_W'(DIGIT_COUNT - 1)) ? '0 :
                       scan_index_reg + SCAN_W'(1);

    // divider operand setup: numerator (x - lo) * 100 and span hi - lo, as magnitudes
    assign ld_x        = cmd.div_sel ? reading_b_reg   : reading_a_reg;
    assign ld_lo       = cmd.div_sel ? span_b_low_reg  : span_a_low_reg;
    assign ld_hi       = cmd.div_sel ? span_b_high_reg : span_a_high_reg;
    assign ld_diff     = $signed({1'b0, ld_x}) - $signed({1'b0, ld_lo});
    assign ld_span     = $signed({1'b0, ld_hi}) - $signed({1'b0, ld_lo});
    assign ld_prod     = MAP_W'(ld_diff) * MAP_W'(PCT_SCALE);
    assign ld_prod_mag = ld_prod[MAP_W-1] ? QUO_W'(-ld_prod) : QUO_W'(ld_prod);
    assign ld_span_mag = ld_span[SPAN_W-1] ? SAMPLE_BITS'(-ld_span) : SAMPLE_BITS'(ld_span);

    // one restoring step a cycle, quotient bits shift in behind the dividend
    assign rem_shift = {rem_reg, dvd_reg[QUO_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dsr_reg};
    assign quo_s     = $signed({1'b0, dvd_reg});
    assign quo_val   = div_neg_reg ? -quo_s : quo_s;

    // plausibility and truncating average
    assign sum      = SUM_W'(map_a_reg) + SUM_W'(map_b_reg);
    assign diff     = SUM_W'(map_a_reg) - SUM_W'(map_b_reg);
    assign abs_diff = diff[SUM_W-1] ? -diff : diff;
    assign avg_num  = sum + SUM_W'(sum[SUM_W-1]);
    assign avg      = $signed(avg_num) >>> 1;
    assign chk_err  = zero_a_reg || zero_b_reg ||
                      ($unsigned(abs_diff) >= SUM_W'(tolerance_reg)) ||
                      avg[SUM_W-1] || (avg > $signed(SUM_W'(POS_MAX)));

    assign out_idx   = cmd.tick ? scan_next : scan_index_reg;
    assign cur_fault = codes_reg[0] >= CODE_E;
    assign cur_pos   = cur_fault ? '0 :
                       POS_W'(codes_reg[0]) * POS_W'(PCT_SCALE) +
                       POS_W'(codes_reg[1]) * POS_W'(DEC_BASE) + POS_W'(codes_reg[2]);

    assign status.hund_ge  = dig_rem_reg >= POS_W'(PCT_SCALE);
    assign status.tens_ge  = dig_rem_reg >= POS_W'(DEC_BASE);
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_a_low_reg  <= RST_SPAN_A_LOW;
            span_a_high_reg <= RST_SPAN_A_HIGH;
            span_b_low_reg  <= RST_SPAN_B_LOW;
            span_b_high_reg <= RST_SPAN_B_HIGH;
            tolerance_reg   <= RST_TOLERANCE;
            reading_a_reg   <= '0;
            reading_b_reg   <= '0;
            scan_index_reg  <= '0;
            codes_reg[0]    <= CODE_E;
            codes_reg[1]    <= CODE_R;
            codes_reg[2]    <= CODE_R;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.cfg_we) begin
                unique case (cfg_addr)
                    CFG_SPAN_A_LOW:  span_a_low_reg  <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_SPAN_A_HIGH: span_a_high_reg <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_SPAN_B_LOW:  span_b_low_reg  <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_SPAN_B_HIGH: span_b_high_reg <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_TOLERANCE:   tolerance_reg   <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.sample_we) begin
                if (s_tuser[1] == CH_B) begin
                    reading_b_reg <= s_tdata[SAMPLE_BITS-1:0];
                end else begin
                    reading_a_reg <= s_tdata[SAMPLE_BITS-1:0];
                end
            end
            if (cmd.tick) begin
                scan_index_reg <= scan_next;
            end
            if (cmd.commit) begin
                if (err_reg) begin
                    codes_reg[0] <= CODE_E;
                    codes_reg[1] <= CODE_R;
                    codes_reg[2] <= CODE_R;
                end else begin
                    codes_reg[0] <= hund_reg;
                    codes_reg[1] <= tens_reg;
                    codes_reg[2] <= dig_rem_reg[CODE_W-1:0];
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dvd_reg     <= ld_prod_mag;
            dsr_reg     <= ld_span_mag;
            rem_reg     <= '0;
            div_neg_reg <= ld_prod[MAP_W-1] ^ ld_span[SPAN_W-1];
            if (cmd.div_sel) begin
                zero_b_reg <= (ld_span == '0);
            end else begin
                zero_a_reg <= (ld_span == '0);
            end
        end
        if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[QUO_W-2:0], rem_ge};
            rem_reg <= rem_ge ? SAMPLE_BITS'(rem_shift - {1'b0, dsr_reg}) :
                                rem_shift[SAMPLE_BITS-1:0];
        end
        if (cmd.div_store) begin
            if (cmd.div_sel) begin
                map_b_reg <= quo_val;
            end else begin
                map_a_reg <= quo_val;
            end
        end
        if (cmd.check) begin
            err_reg     <= chk_err;
            dig_rem_reg <= chk_err ? '0 : avg[POS_W-1:0];
            hund_reg    <= '0;
            tens_reg    <= '0;
        end
        if (cmd.hund_step) begin
            dig_rem_reg <= dig_rem_reg - POS_W'(PCT_SCALE);
            hund_reg    <= hund_reg + CODE_W'(1);
        end
        if (cmd.tens_step) begin
            dig_rem_reg <= dig_rem_reg - POS_W'(DEC_BASE);
            tens_reg    <= tens_reg + CODE_W'(1);
        end
        if (cmd.out_load) begin
            seg_reg   <= glyph(codes_reg[out_idx]);
            en_reg    <= DIGIT_COUNT'(1) << out_idx;
            pos_reg   <= cur_pos;
            fault_reg <= cur_fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({fault_reg, pos_reg, en_reg, seg_reg});

endmodule

### rtl/core/dspd_ctrl.sv
// sequencer for config writes, samples and scan ticks of the plausibility display core
`timescale 1ns / 1ps

module dspd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  s_tvalid,
    input  logic                  s_opcode,
    output logic                  s_tready,
    input  dspd_pkg::dp_status_t  status,
    output dspd_pkg::dp_cmd_t     cmd
);
    import dspd_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic              emit_reg, emit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        cfg_ready  = 1'b0;
        s_tready   = 1'b0;
        cmd.div_sel = sel_reg;

        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = status.out_free && !cfg_valid;
                if (cfg_valid) begin
                    // register changes rerun the check without a result word
                    cmd.cfg_we = 1'b1;
                    emit_next  = 1'b0;
                    sel_next   = 1'b0;
                    state_next = ST_LOAD;
                end else if (s_tvalid && status.out_free) begin
                    if (s_opcode == OP_TICK) begin
                        cmd.tick     = 1'b1;
                        cmd.out_load = 1'b1;
                    end else begin
                        cmd.sample_we = 1'b1;
                        emit_next     = 1'b1;
                        sel_next      = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.div_store = 1'b1;
                if (sel_reg == CH_A) begin
                    sel_next   = CH_B;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_HUND;
            end
            ST_HUND: begin
                if (status.hund_ge) begin
                    cmd.hund_step = 1'b1;
                end else begin
                    state_next = ST_TENS;
                end
            end
            ST_TENS: begin
                if (status.tens_ge) begin
                    cmd.tens_step = 1'b1;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/dual_sensor_plausibility_display_core.sv
// top level of the dual sensor plausibility check with scanned three-digit display
//
//  channel   direction  fields (lowest bit first)
//  s_        in         tuser: opcode, channel / tdata: sample[9:0]
//  m_        out        tdata: segments[6:0], digit_enable[9:7], position[19:10], fault[20]
//  cfg_      in         cfg_addr: register index / cfg_data: value
//
// a scan tick gives its result word in the cycle after acceptance
// a sample runs two 17-step divisions on the shared bit-serial span divider, then the
// plausibility check and the digit split by repeated subtraction
// a register write reruns the same sequence with no result word
// sync active-low reset restores the default spans and shows Err
// a stalled result word holds; a tick can be taken in the cycle the word leaves
`timescale 1ns / 1ps

module dual_sensor_plausibility_display_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dspd_pkg::S_TDATA_W-1:0]   s_tdata,  // sample[9:0], zero fill
    input  logic [dspd_pkg::S_TUSER_W-1:0]   s_tuser,  // opcode[0], channel[1]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dspd_pkg::M_TDATA_W-1:0]   m_tdata,  // segments, digit_enable, position, fault
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dspd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dspd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dspd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dspd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_tvalid  (s_tvalid),
        .s_opcode  (s_tuser[0]),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dspd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/core/dspd_checker.sv
// port-level checks of the plausibility display core and their bind
`timescale 1ns / 1ps
`include "dual_sensor_plausibility_display_core_assert.svh"

module dspd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dspd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dspd_pkg::*;

    // exactly one digit driven per word
    `DSPD_ASSERT_IMP(a_digit_onehot, m_tvalid, $onehot(m_tdata[9:7]))

    // an error display never reports a position
    `DSPD_ASSERT_IMP(a_fault_pos_zero, m_tvalid && m_tdata[20], m_tdata[19:10] == '0)

    // a valid word's position fits three digits
    `DSPD_ASSERT_IMP(a_pos_range, m_tvalid, m_tdata[19:10] <= POS_W'(POS_MAX))

    `DSPD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind dual_sensor_plausibility_display_core dspd_checker u_dspd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
